// File: rtl/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg: shared constants for the track average speed block
// Field widths, time conversion factors and the default coordinate width.
// ----------------------------------------------------------------------------
package tas_pkg;

    // default coordinate width (Q24.8 meters)
    localparam int COORD_WIDTH_DEF = 32;

    // accumulator and result widths
    localparam int DIST_W     = 64;
    localparam int TSEC_W     = 40;
    localparam int SPEED_W    = 32;
    localparam int FRAC_SHIFT = 8;
    localparam int LEG_SECS_W = 20;

    // interval conversion
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

endpackage

// File: rtl/tas_sqsum.sv
// ----------------------------------------------------------------------------
// tas_sqsum: bit-serial sum of squares
// Computes |dx|^2 + |dy|^2, one multiplier bit of each operand per cycle,
// most significant bit first, into a shift-and-add accumulator.
// ----------------------------------------------------------------------------
module tas_sqsum #(
    parameter int W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [W-1:0]   i_dx,
    input  logic signed [W-1:0]   i_dy,
    output logic                  o_done,
    output logic [2*W:0]          o_sum
);
    localparam int SW    = 2 * W + 1;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_ax, r_ay;
    logic [W-1:0]     r_bx, r_by;
    logic [SW-1:0]    r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W-1:0]  mag_x, mag_y;
    logic [SW-1:0] n_acc;

    // magnitudes of the signed differences
    assign mag_x = i_dx[W-1] ? (~i_dx + W'(1)) : i_dx;
    assign mag_y = i_dy[W-1] ? (~i_dy + W'(1)) : i_dy;

    // one shift-and-add step for both squares
    assign n_acc = {r_acc[SW-2:0], 1'b0}
                 + (r_bx[W-1] ? SW'(r_ax) : SW'(0))
                 + (r_by[W-1] ? SW'(r_ay) : SW'(0));

    // sequencing and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_ax  <= mag_x;
            r_ay  <= mag_y;
            r_bx  <= mag_x;
            r_by  <= mag_y;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_bx  <= {r_bx[W-2:0], 1'b0};
            r_by  <= {r_by[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

// File: rtl/tas_isqrt.sv
// ----------------------------------------------------------------------------
// tas_isqrt: digit-serial integer square root
// Restoring root extraction, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module tas_isqrt #(
    parameter int RW = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2*RW-1:0]   i_rad,
    output logic              o_done,
    output logic [RW-1:0]     o_root
);
    localparam int NW    = 2 * RW;
    localparam int RMW   = RW + 2;
    localparam int CNT_W = $clog2(RW);

    logic [NW-1:0]    r_n;
    logic [RMW-1:0]   r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RMW+1:0] rem_sh;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] rem_sub;
    logic           ge;

    // bring down two radicand bits and try the next root bit
    assign rem_sh  = {r_rem, r_n[NW-1:NW-2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // radicand shift line, partial remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_n    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[NW-3:0], 2'b00};
            r_rem  <= ge ? rem_sub[RMW-1:0] : rem_sh[RMW-1:0];
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/tas_div.sv
// ----------------------------------------------------------------------------
// tas_div: bit-serial speed divider
// Restoring division of (distance << 8) by total seconds, one quotient bit
// per cycle, with saturation once the quotient outgrows the speed width.
// ----------------------------------------------------------------------------
module tas_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tas_pkg::DIST_W-1:0]  i_dist,
    input  logic [tas_pkg::TSEC_W-1:0]  i_secs,
    output logic                        o_done,
    output logic [tas_pkg::SPEED_W-1:0] o_speed
);
    import tas_pkg::*;

    localparam int DW    = DIST_W + FRAC_SHIFT;
    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]      r_n;
    logic [TSEC_W-1:0]  r_d;
    logic [TSEC_W-1:0]  r_rem;
    logic [SPEED_W-1:0] r_q;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [TSEC_W:0] rem_sh;
    logic [TSEC_W:0] rem_sub;
    logic            ge;

    // bring down one dividend bit and compare
    assign rem_sh  = {r_rem, r_n[DW-1]};
    assign ge      = (rem_sh >= {1'b0, r_d});
    assign rem_sub = rem_sh - {1'b0, r_d};

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shift line, remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_n   <= {i_dist, FRAC_SHIFT'(0)};
            r_d   <= i_secs;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_n   <= {r_n[DW-2:0], 1'b0};
            r_rem <= ge ? rem_sub[TSEC_W-1:0] : rem_sh[TSEC_W-1:0];
            r_q   <= {r_q[SPEED_W-2:0], ge};
            // a one leaving the top means the speed does not fit
            r_sat <= r_sat | r_q[SPEED_W-1];
        end
    end

    assign o_done  = r_done;
    assign o_speed = r_sat ? '1 : r_q;

endmodule

// File: rtl/track_average_speed.sv
// ----------------------------------------------------------------------------
// track_average_speed: average speed over a track of points
// Sums leg lengths (root of summed squares) and leg durations, and on the
// last point divides distance by time into an unsigned Q16.16 speed.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  point in | i_valid / o_ready  | i_pos_x, i_pos_y, i_hours, i_minutes,
//           |                    | i_seconds, i_last_point
//  speed out| o_valid / i_ready  | o_speed, o_zero_time
//
//  A point after the first runs a bit-serial square-sum pass (COORD_WIDTH+1
//  steps) then the root extraction (COORD_WIDTH+2 steps). The last point
//  then runs the 72-step divider when the total time is nonzero. The first
//  point of a track only records its position; when it is also the last
//  point, it goes straight to a zero-time result.
//  Reset is synchronous and clears all totals. A stalled result sits in the
//  output register; the next point is taken meanwhile and only the next
//  last-point result waits for it to drain.
// ----------------------------------------------------------------------------
module track_average_speed #(
    parameter int COORD_WIDTH = tas_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [COORD_WIDTH-1:0]      i_pos_x,
    input  logic [COORD_WIDTH-1:0]      i_pos_y,
    input  logic [7:0]                  i_hours,
    input  logic [5:0]                  i_minutes,
    input  logic [5:0]                  i_seconds,
    input  logic                        i_last_point,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tas_pkg::SPEED_W-1:0] o_speed,
    output logic                        o_zero_time
);
    import tas_pkg::*;

    localparam int W  = COORD_WIDTH + 1;
    localparam int SW = 2 * W + 1;
    localparam int RW = COORD_WIDTH + 2;
    localparam int NW = 2 * RW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_RT,
        ST_DCHK,
        ST_DIV,
        ST_PUB
    } t_state;

    t_state r_state;

    logic [COORD_WIDTH-1:0] r_prev_x, r_prev_y;
    logic                   r_have_prev;
    logic [DIST_W-1:0]      r_tdist;
    logic [TSEC_W-1:0]      r_tsec;
    logic                   r_last;
    logic signed [W-1:0]    r_dx, r_dy;
    logic [SPEED_W-1:0]     r_res_speed;
    logic                   r_res_zero;
    logic                   r_o_valid;
    logic [SPEED_W-1:0]     r_o_speed;
    logic                   r_o_zero;

    logic                  accept;
    logic signed [W-1:0]   x_ext, y_ext, px_ext, py_ext;
    logic [LEG_SECS_W-1:0] leg_secs;
    logic [TSEC_W:0]       tsec_sum;
    logic [DIST_W:0]       dist_sum;
    logic                  sq_start, sq_done;
    logic [SW-1:0]         sq_sum;
    logic                  rt_start, rt_done;
    logic [RW-1:0]         rt_root;
    logic                  div_start, div_done;
    logic [SPEED_W-1:0]    div_speed;
    logic                  out_free;
    logic                  publish;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign publish  = (r_state == ST_PUB) && out_free;

    // sign-extended coordinates for the differences
    assign x_ext  = {i_pos_x[COORD_WIDTH-1], i_pos_x};
    assign y_ext  = {i_pos_y[COORD_WIDTH-1], i_pos_y};
    assign px_ext = {r_prev_x[COORD_WIDTH-1], r_prev_x};
    assign py_ext = {r_prev_y[COORD_WIDTH-1], r_prev_y};

    // leg duration in seconds and the saturating totals
    assign leg_secs = LEG_SECS_W'(i_hours) * LEG_SECS_W'(SECS_PER_HOUR)
                    + LEG_SECS_W'(i_minutes) * LEG_SECS_W'(SECS_PER_MIN)
                    + LEG_SECS_W'(i_seconds);
    assign tsec_sum = {1'b0, r_tsec} + (TSEC_W + 1)'(leg_secs);
    assign dist_sum = {1'b0, r_tdist} + (DIST_W + 1)'(rt_root);

    // unit starts
    assign sq_start  = (r_state == ST_LOAD);
    assign rt_start  = sq_done;
    assign div_start = (r_state == ST_DCHK) && (r_tsec != '0);

    tas_sqsum #(.W(W)) u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_done  (sq_done),
        .o_sum   (sq_sum)
    );

    tas_isqrt #(.RW(RW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rt_start),
        .i_rad   (NW'(sq_sum)),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    tas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dist  (r_tdist),
        .i_secs  (r_tsec),
        .o_done  (div_done),
        .o_speed (div_speed)
    );

    // track state, sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_tdist     <= '0;
            r_tsec      <= '0;
            r_last      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !publish) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_prev_x    <= i_pos_x;
                        r_prev_y    <= i_pos_y;
                        r_have_prev <= 1'b1;
                        r_last      <= i_last_point;
                        if (r_have_prev) begin
                            r_tsec  <= tsec_sum[TSEC_W] ? '1 : tsec_sum[TSEC_W-1:0];
                            r_state <= ST_LOAD;
                        end else if (i_last_point) begin
                            r_state <= ST_DCHK;
                        end
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    if (sq_done) begin
                        r_state <= ST_RT;
                    end
                end
                ST_RT: begin
                    if (rt_done) begin
                        r_tdist <= dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
                        r_state <= r_last ? ST_DCHK : ST_IDLE;
                    end
                end
                ST_DCHK: begin
                    r_state <= (r_tsec == '0) ? ST_PUB : ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_PUB;
                    end
                end
                ST_PUB: begin
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_prev_x    <= '0;
                        r_prev_y    <= '0;
                        r_have_prev <= 1'b0;
                        r_tdist     <= '0;
                        r_tsec      <= '0;
                        r_last      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx <= x_ext - px_ext;
            r_dy <= y_ext - py_ext;
        end
        if (r_state == ST_DCHK) begin
            r_res_speed <= '0;
            r_res_zero  <= (r_tsec == '0);
        end else if (div_done) begin
            r_res_speed <= div_speed;
        end
        if (publish) begin
            r_o_speed <= r_res_speed;
            r_o_zero  <= r_res_zero;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_speed     = r_o_speed;
    assign o_zero_time = r_o_zero;

`ifndef SYNTH
    // a track with no previous point has empty totals
    a_empty_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_prev |-> (r_tdist == '0) && (r_tsec == '0))
        else $error("totals nonzero without a previous point");

    // zero total time reports a zero speed
    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_time |-> (o_speed == '0))
        else $error("zero_time with nonzero speed");

    // unit completions arrive only in the state waiting for them
    a_sq_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_SQ))
        else $error("square-sum done outside its phase");

    a_rt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rt_done |-> (r_state == ST_RT))
        else $error("root done outside its phase");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside its phase");
`endif

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for track_average_speed
// Feeds tracks of points through the valid/ready input, predicts the average
// speed of every finished track in a local model and checks each result
// transaction field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

    import tas_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [CW-1:0] pos_x;
        logic [CW-1:0] pos_y;
        logic [7:0]    hours;
        logic [5:0]    minutes;
        logic [5:0]    seconds;
        logic          last_point;
    } t_track_point;

    typedef struct {
        logic [SPEED_W-1:0] speed;
        logic               zero_time;
    } t_speed_result;

    // clock and dut ports
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    logic [CW-1:0]       i_pos_x      = '0;
    logic [CW-1:0]       i_pos_y      = '0;
    logic [7:0]          i_hours      = '0;
    logic [5:0]          i_minutes    = '0;
    logic [5:0]          i_seconds    = '0;
    logic                i_last_point = 1'b0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    logic [SPEED_W-1:0]  o_speed;
    logic                o_zero_time;

    // stimulus and expectations
    t_track_point  pending_points[$];
    t_speed_result expected_speeds[$];
    t_track_point  point_on_bus;
    t_speed_result exp_speed;
    int            total_points;
    int            accepted_points = 0;
    int            send_idle_pct   = 29;
    int            recv_idle_pct   = 53;
    int            error_count     = 0;
    int            cycle_count     = 0;

    // track state of the local model
    logic [CW-1:0]     prev_x;
    logic [CW-1:0]     prev_y;
    logic              have_prev;
    logic [DIST_W-1:0] total_dist;
    logic [TSEC_W-1:0] total_secs;

    track_average_speed u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_hours      (i_hours),
        .i_minutes    (i_minutes),
        .i_seconds    (i_seconds),
        .i_last_point (i_last_point),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_speed      (o_speed),
        .o_zero_time  (o_zero_time)
    );

    // 10 unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void clear_track();
        prev_x     = '0;
        prev_y     = '0;
        have_prev  = 1'b0;
        total_dist = '0;
        total_secs = '0;
    endfunction

    // floor of the straight-line distance between two points, q.8 meters
    function automatic logic [63:0] leg_length_q8(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                                  logic [CW-1:0] bx, logic [CW-1:0] by);
        logic signed [CW+1:0] dx;
        logic signed [CW+1:0] dy;
        logic [127:0]         adx;
        logic [127:0]         ady;
        logic [127:0]         sum_sq;
        logic [127:0]         trial;
        logic [63:0]          root;
        dx = $signed({ax[CW-1], ax}) - $signed({bx[CW-1], bx});
        dy = $signed({ay[CW-1], ay}) - $signed({by[CW-1], by});
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        adx    = 128'(unsigned'(dx));
        ady    = 128'(unsigned'(dy));
        sum_sq = adx * adx + ady * ady;
        root   = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = 128'(root | (64'd1 << b));
            if (trial * trial <= sum_sq) root = trial[63:0];
        end
        return root;
    endfunction

    // distance over time as q16.16, saturated
    function automatic logic [SPEED_W-1:0] speed_q16(logic [DIST_W-1:0] dist_q8,
                                                      logic [TSEC_W-1:0] secs);
        logic [127:0] num;
        logic [127:0] quot;
        num  = 128'(dist_q8) << FRAC_SHIFT;
        quot = num / 128'(secs);
        if (quot > 128'hFFFF_FFFF) return '1;
        return quot[SPEED_W-1:0];
    endfunction

    // advance the model by one accepted point
    function automatic void predict_point(t_track_point p);
        logic [DIST_W:0]   dist_sum;
        logic [TSEC_W:0]   secs_sum;
        logic [LEG_SECS_W-1:0] leg_secs;
        t_speed_result     res;
        leg_secs = LEG_SECS_W'(p.hours * SECS_PER_HOUR + p.minutes * SECS_PER_MIN
                               + p.seconds);
        if (have_prev) begin
            dist_sum   = (DIST_W + 1)'(total_dist)
                       + (DIST_W + 1)'(leg_length_q8(p.pos_x, p.pos_y, prev_x, prev_y));
            total_dist = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
            secs_sum   = (TSEC_W + 1)'(total_secs) + (TSEC_W + 1)'(leg_secs);
            total_secs = secs_sum[TSEC_W] ? '1 : secs_sum[TSEC_W-1:0];
        end
        prev_x    = p.pos_x;
        prev_y    = p.pos_y;
        have_prev = 1'b1;
        if (p.last_point) begin
            if (total_secs == 0) begin
                res.speed     = '0;
                res.zero_time = 1'b1;
            end else begin
                res.speed     = speed_q16(total_dist, total_secs);
                res.zero_time = 1'b0;
            end
            expected_speeds.push_back(res);
            clear_track();
        end
    endfunction

    task automatic add_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [7:0] h, input logic [5:0] m,
                             input logic [5:0] s, input logic lp);
        t_track_point p;
        p.pos_x      = x;
        p.pos_y      = y;
        p.hours      = h;
        p.minutes    = m;
        p.seconds    = s;
        p.last_point = lp;
        pending_points.push_back(p);
    endtask

    // one random track: walk, wide jumps or corner coordinates
    task automatic add_random_track();
        int            npts;
        int            coord_mode;
        int            dur_mode;
        int            step;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [7:0]    h;
        logic [5:0]    m;
        logic [5:0]    s;
        npts       = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
        coord_mode = $urandom_range(9);
        dur_mode   = $urandom_range(9);
        step       = 1 << $urandom_range(20, 4);
        x          = $urandom;
        y          = $urandom;
        for (int i = 0; i < npts; i++) begin
            if (coord_mode < 6) begin
                x = x + $urandom_range(2 * step) - step;
                y = y + $urandom_range(2 * step) - step;
            end else if (coord_mode < 9) begin
                x = $urandom;
                y = $urandom;
            end else begin
                case ($urandom_range(3))
                    0: x = {1'b1, {(CW-1){1'b0}}};
                    1: x = {1'b0, {(CW-1){1'b1}}};
                    2: x = '0;
                    default: x = '1;
                endcase
                case ($urandom_range(3))
                    0: y = {1'b1, {(CW-1){1'b0}}};
                    1: y = {1'b0, {(CW-1){1'b1}}};
                    2: y = '0;
                    default: y = '1;
                endcase
            end
            if (dur_mode == 0) begin
                h = '0;
                m = '0;
                s = '0;
            end else begin
                h = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(2);
                m = $urandom_range(63);
                s = $urandom_range(63);
                if (dur_mode == 1) begin
                    h = '0;
                    m = '0;
                    s = $urandom_range(3);
                end
            end
            add_point(x, y, h, m, s, i == npts - 1);
        end
    endtask

    // input driver: one transaction per handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_point(point_on_bus);
                accepted_points++;
                if (accepted_points >= 2 * total_points / 3) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end else if (accepted_points >= total_points / 3) begin
                    send_idle_pct = 53;
                    recv_idle_pct = 29;
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    point_on_bus = pending_points.pop_front();
                    i_pos_x      <= point_on_bus.pos_x;
                    i_pos_y      <= point_on_bus.pos_y;
                    i_hours      <= point_on_bus.hours;
                    i_minutes    <= point_on_bus.minutes;
                    i_seconds    <= point_on_bus.seconds;
                    i_last_point <= point_on_bus.last_point;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_speeds.size() == 0) begin
                    report_mismatch($sformatf("unexpected result speed=%h zero_time=%b",
                                              o_speed, o_zero_time));
                end else begin
                    exp_speed = expected_speeds.pop_front();
                    if (o_speed !== exp_speed.speed)
                        report_mismatch($sformatf("speed got %h exp %h",
                                                  o_speed, exp_speed.speed));
                    if (o_zero_time !== exp_speed.zero_time)
                        report_mismatch($sformatf("zero_time got %b exp %b",
                                                  o_zero_time, exp_speed.zero_time));
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        clear_track();
        // single point track has no time
        add_point('0, '0, 8'd0, 6'd0, 6'd0, 1'b1);
        // first interval is ignored, remaining time is zero
        add_point(32'd100, 32'd200, 8'd255, 6'd63, 6'd63, 1'b0);
        add_point(32'd100, 32'd200, 8'd0, 6'd0, 6'd0, 1'b1);
        // corner to corner in one second saturates the speed
        add_point(32'h8000_0000, 32'h8000_0000, 8'd255, 6'd59, 6'd59, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 6'd0, 6'd1, 1'b1);
        // extreme coordinates, long and oversized intervals
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 6'd0, 6'd0, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 8'd255, 6'd63, 6'd63, 1'b0);
        add_point('0, '0, 8'd0, 6'd60, 6'd60, 1'b0);
        add_point('1, '1, 8'd0, 6'd0, 6'd0, 1'b1);
        // 3-4-5 leg, 5 m/s
        add_point('0, '0, 8'd7, 6'd0, 6'd0, 1'b0);
        add_point(32'd768, 32'd1024, 8'd0, 6'd0, 6'd1, 1'b1);
        // negative coordinates, hour and minute legs
        add_point(-32'sd256, -32'sd256, 8'd0, 6'd0, 6'd0, 1'b0);
        add_point(-32'sd256, 32'sd2560, 8'd1, 6'd0, 6'd0, 1'b0);
        add_point(32'sd5000, -32'sd77, 8'd0, 6'd1, 6'd0, 1'b1);
        // no movement with time gives speed zero
        add_point(32'd5, 32'd5, 8'd0, 6'd0, 6'd0, 1'b0);
        add_point(32'd5, 32'd5, 8'd0, 6'd0, 6'd10, 1'b1);
        while (pending_points.size() < RANDOM_ITEMS)
            add_random_track();
        total_points = pending_points.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_points.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_speeds.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
